### design/mbt_pkg.sv
// mbt_pkg: token kinds, error codes and the per-result record of the byte tokenizer
// shared by the front, the back and the top level; no dependencies
package mbt_pkg;

  typedef enum logic [3:0] {
    TOK_EOF    = 4'd0,
    TOK_IDENT  = 4'd1,
    TOK_NUMBER = 4'd2,
    TOK_STRING = 4'd3,
    TOK_BOOL   = 4'd4,
    TOK_COMMA  = 4'd5,
    TOK_PIPE   = 4'd6,
    TOK_LBRACE = 4'd7,
    TOK_RBRACE = 4'd8,
    TOK_COLON  = 4'd9
  } tok_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNEXPECTED = 3'd1,
    ERR_UNTERM_STR = 3'd2,
    ERR_BAD_NUMBER = 3'd3,
    ERR_BAD_REF    = 3'd4
  } err_code_e;

  // most result beats one input beat can cause
  localparam int unsigned MaxResults = 3;
  // bundles held between front and back
  localparam int unsigned QueueDepth = 4;

  typedef logic [1:0] rcnt_t;

  // one result without its position
  typedef struct packed {
    tok_kind_e kind;
    logic [7:0] text;
    logic       text_valid;
    logic       done;
    err_code_e  err;
  } rslt_t;

endpackage

### design/mbt_if.sv
// mbt_in_if / mbt_out_if: valid-ready channels of the byte tokenizer
// no package dependency; the result channel is sized by the position width
interface mbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       byte_valid;
  logic       end_of_source;

  modport source (output valid, source_byte, byte_valid, end_of_source, input ready);
  modport sink   (input valid, source_byte, byte_valid, end_of_source, output ready);
endinterface

interface mbt_out_if #(
  parameter int unsigned PW = 16
);
  logic          valid;
  logic          ready;
  logic [3:0]    token_kind;
  logic [7:0]    text_byte;
  logic          text_valid;
  logic          token_done;
  logic [PW-1:0] start_line;
  logic [PW-1:0] start_column;
  logic [2:0]    error_code;
  logic          last_of_item;

  modport source (output valid, token_kind, text_byte, text_valid, token_done, start_line,
                  start_column, error_code, last_of_item, input ready);
  modport sink   (input valid, token_kind, text_byte, text_valid, token_done, start_line,
                  start_column, error_code, last_of_item, output ready);
endinterface

### design/mbt_front.sv
// mbt_front: lexer state machine, takes one source beat a cycle unless the queue is full, and builds its result bundle
// depends on mbt_pkg and mbt_in_if
module mbt_front #(
  parameter int unsigned PW = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mbt_in_if.sink in_i,
  input  logic full_i,
  output logic push_o,
  output mbt_pkg::rcnt_t cnt_o,
  output mbt_pkg::rslt_t [mbt_pkg::MaxResults-1:0] meta_o,
  output logic [mbt_pkg::MaxResults-1:0][PW-1:0] line_o,
  output logic [mbt_pkg::MaxResults-1:0][PW-1:0] col_o
);

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_LCOM, M_BCOM, M_BSTAR, M_IDENT, M_RESAT, M_NUM, M_STR, M_ESC, M_ERR
  } mode_e;

  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowE   = 8'h65;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowL   = 8'h6C;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowS   = 8'h73;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChPipe   = 8'h7C;
  localparam logic [7:0] ChRbrace = 8'h7D;

  // keyword prefix tracker codes
  localparam logic [3:0] BmNone  = 4'd0;
  localparam logic [3:0] BmT     = 4'd1;
  localparam logic [3:0] BmTr    = 4'd2;
  localparam logic [3:0] BmTru   = 4'd3;
  localparam logic [3:0] BmTrue  = 4'd4;
  localparam logic [3:0] BmF     = 4'd5;
  localparam logic [3:0] BmFa    = 4'd6;
  localparam logic [3:0] BmFal   = 4'd7;
  localparam logic [3:0] BmFals  = 4'd8;
  localparam logic [3:0] BmFalse = 4'd9;

  // number flag bits
  localparam logic [2:0] NfSign  = 3'b001;
  localparam logic [2:0] NfDig   = 3'b010;
  localparam logic [2:0] NfPoint = 3'b100;

  localparam logic [PW-1:0] PosOne = PW'(1);

  function automatic logic is_digit(input logic [7:0] ch);
    return ch inside {[8'h30:8'h39]};
  endfunction

  function automatic logic ident_start(input logic [7:0] ch);
    return (ch inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || ch == ChUscore;
  endfunction

  function automatic logic ident_char(input logic [7:0] ch);
    return ident_start(ch) || is_digit(ch) || ch == ChDot;
  endfunction

  function automatic logic [3:0] bool_next(input logic [3:0] m, input logic [7:0] ch);
    logic [3:0] r;
    r = BmNone;
    case (m)
      BmT:    if (ch == ChLowR) r = BmTr;
      BmTr:   if (ch == ChLowU) r = BmTru;
      BmTru:  if (ch == ChLowE) r = BmTrue;
      BmF:    if (ch == ChLowA) r = BmFa;
      BmFa:   if (ch == ChLowL) r = BmFal;
      BmFal:  if (ch == ChLowS) r = BmFals;
      BmFals: if (ch == ChLowE) r = BmFalse;
      default: r = BmNone;
    endcase
    return r;
  endfunction

  function automatic mbt_pkg::tok_kind_e ident_kind(input logic [3:0] m);
    return (m == BmTrue || m == BmFalse) ? mbt_pkg::TOK_BOOL : mbt_pkg::TOK_IDENT;
  endfunction

  function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] v);
    return (&v) ? v : v + PosOne;
  endfunction

  function automatic mbt_pkg::rslt_t mk(input mbt_pkg::tok_kind_e kind, input logic [7:0] tb,
                                        input logic tv, input logic dn,
                                        input mbt_pkg::err_code_e err);
    mbt_pkg::rslt_t r;
    r.kind       = kind;
    r.text       = tb;
    r.text_valid = tv;
    r.done       = dn;
    r.err        = err;
    return r;
  endfunction

  mode_e              mode_q, mode_d;
  logic [PW-1:0]      cur_line_q, cur_line_d, cur_col_q, cur_col_d;
  logic [PW-1:0]      tok_line_q, tok_line_d, tok_col_q, tok_col_d;
  logic [2:0]         nflags_q, nflags_d;
  logic [3:0]         bm_q, bm_d;
  mbt_pkg::err_code_e err_q, err_d;

  logic [7:0]         c;
  logic               acc, take, start, eos_close;
  mbt_pkg::tok_kind_e eos_kind;
  logic               a_v, b_v, c_v, d_v;
  mbt_pkg::rslt_t     a_r, b_r, c_r, d_r;
  logic [PW-1:0]      bc_line, bc_col, e_line, e_col;
  mbt_pkg::rcnt_t     n;

  assign c          = in_i.source_byte;
  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;

  always_comb begin
    mode_d     = mode_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    nflags_d   = nflags_q;
    bm_d       = bm_q;
    err_d      = err_q;
    take       = in_i.byte_valid && mode_q != M_ERR;
    start      = 1'b0;
    eos_close  = 1'b0;
    eos_kind   = mbt_pkg::TOK_EOF;
    a_v = 1'b0; b_v = 1'b0; c_v = 1'b0; d_v = 1'b0;
    a_r = '0; b_r = '0; c_r = '0; d_r = '0;

    if (take) begin
      case (mode_q)
        M_IDLE: start = 1'b1;
        M_SLASH: begin
          if (c == ChSlash) begin
            mode_d = M_LCOM;
          end else if (c == ChStar) begin
            mode_d = M_BCOM;
          end else begin
            err_d  = mbt_pkg::ERR_UNEXPECTED;
            mode_d = M_ERR;
            b_v    = 1'b1;
            b_r    = mk(mbt_pkg::TOK_EOF, 8'h00, 1'b0, 1'b0, err_d);
          end
        end
        M_LCOM: if (c == ChLf) mode_d = M_IDLE;
        M_BCOM: if (c == ChStar) mode_d = M_BSTAR;
        M_BSTAR: begin
          if (c == ChSlash) mode_d = M_IDLE;
          else if (c != ChStar) mode_d = M_BCOM;
        end
        M_IDENT: begin
          if (ident_char(c)) begin
            bm_d = bool_next(bm_q, c);
            b_v  = 1'b1;
            b_r  = mk(mbt_pkg::TOK_IDENT, c, 1'b1, 1'b0, err_d);
          end else begin
            a_v   = 1'b1;
            a_r   = mk(ident_kind(bm_q), 8'h00, 1'b0, 1'b1, err_d);
            start = 1'b1;
          end
        end
        M_RESAT: begin
          if (ident_start(c)) begin
            bm_d   = BmNone;
            b_v    = 1'b1;
            b_r    = mk(mbt_pkg::TOK_IDENT, c, 1'b1, 1'b0, err_d);
            mode_d = M_IDENT;
          end else begin
            err_d  = mbt_pkg::ERR_BAD_REF;
            mode_d = M_ERR;
            b_v    = 1'b1;
            b_r    = mk(mbt_pkg::TOK_EOF, 8'h00, 1'b0, 1'b0, err_d);
          end
        end
        M_NUM: begin
          if (is_digit(c)) begin
            nflags_d = nflags_q | NfDig;
            b_v      = 1'b1;
            b_r      = mk(mbt_pkg::TOK_NUMBER, c, 1'b1, 1'b0, err_d);
          end else if (c == ChDot && (nflags_q & NfPoint) == 3'b000) begin
            nflags_d = nflags_q | NfPoint;
            b_v      = 1'b1;
            b_r      = mk(mbt_pkg::TOK_NUMBER, c, 1'b1, 1'b0, err_d);
          end else if ((nflags_q & NfDig) == 3'b000) begin
            err_d  = mbt_pkg::ERR_BAD_NUMBER;
            mode_d = M_ERR;
            b_v    = 1'b1;
            b_r    = mk(mbt_pkg::TOK_EOF, 8'h00, 1'b0, 1'b0, err_d);
          end else begin
            a_v   = 1'b1;
            a_r   = mk(mbt_pkg::TOK_NUMBER, 8'h00, 1'b0, 1'b1, err_d);
            start = 1'b1;
          end
        end
        M_STR: begin
          if (c == ChBslash) begin
            mode_d = M_ESC;
          end else if (c == ChQuote) begin
            b_v    = 1'b1;
            b_r    = mk(mbt_pkg::TOK_STRING, 8'h00, 1'b0, 1'b1, err_d);
            mode_d = M_IDLE;
          end else begin
            b_v = 1'b1;
            b_r = mk(mbt_pkg::TOK_STRING, c, 1'b1, 1'b0, err_d);
          end
        end
        M_ESC: begin
          b_v    = 1'b1;
          b_r    = mk(mbt_pkg::TOK_STRING, c, 1'b1, 1'b0, err_d);
          mode_d = M_STR;
          if (c == ChLowN) b_r.text = ChLf;
          else if (c == ChLowR) b_r.text = ChCr;
          else if (c == ChLowT) b_r.text = ChTab;
        end
        default: ;
      endcase

      // a new token begins here, possibly right after closing the previous one
      if (start) begin
        tok_line_d = cur_line_q;
        tok_col_d  = cur_col_q;
        mode_d     = M_IDLE;
        case (c)
          ChSpace, ChTab, ChCr, ChLf: ;
          ChSlash:  mode_d = M_SLASH;
          ChComma:  begin b_v = 1'b1; b_r = mk(mbt_pkg::TOK_COMMA, 8'h00, 1'b0, 1'b1, err_d); end
          ChPipe:   begin b_v = 1'b1; b_r = mk(mbt_pkg::TOK_PIPE, 8'h00, 1'b0, 1'b1, err_d); end
          ChLbrace: begin b_v = 1'b1; b_r = mk(mbt_pkg::TOK_LBRACE, 8'h00, 1'b0, 1'b1, err_d); end
          ChRbrace: begin b_v = 1'b1; b_r = mk(mbt_pkg::TOK_RBRACE, 8'h00, 1'b0, 1'b1, err_d); end
          ChColon:  begin b_v = 1'b1; b_r = mk(mbt_pkg::TOK_COLON, 8'h00, 1'b0, 1'b1, err_d); end
          ChAt: begin
            b_v    = 1'b1;
            b_r    = mk(mbt_pkg::TOK_IDENT, c, 1'b1, 1'b0, err_d);
            mode_d = M_RESAT;
          end
          ChQuote: mode_d = M_STR;
          default: begin
            if (is_digit(c) || c == ChMinus || c == ChDot) begin
              nflags_d = is_digit(c) ? NfDig : ((c == ChMinus) ? NfSign : NfPoint);
              b_v      = 1'b1;
              b_r      = mk(mbt_pkg::TOK_NUMBER, c, 1'b1, 1'b0, err_d);
              mode_d   = M_NUM;
            end else if (ident_start(c)) begin
              bm_d   = (c == ChLowT) ? BmT : ((c == ChLowF) ? BmF : BmNone);
              b_v    = 1'b1;
              b_r    = mk(mbt_pkg::TOK_IDENT, c, 1'b1, 1'b0, err_d);
              mode_d = M_IDENT;
            end else begin
              err_d  = mbt_pkg::ERR_UNEXPECTED;
              mode_d = M_ERR;
              b_v    = 1'b1;
              b_r    = mk(mbt_pkg::TOK_EOF, 8'h00, 1'b0, 1'b0, err_d);
            end
          end
        endcase
      end

      if (c == ChLf) begin
        cur_line_d = pos_inc(cur_line_q);
        cur_col_d  = PosOne;
      end else begin
        cur_col_d = pos_inc(cur_col_q);
      end
    end

    bc_line = tok_line_d;
    bc_col  = tok_col_d;
    e_line  = cur_line_d;
    e_col   = cur_col_d;

    if (in_i.end_of_source) begin
      case (mode_d)
        M_SLASH: err_d = mbt_pkg::ERR_UNEXPECTED;
        M_IDENT: begin eos_close = 1'b1; eos_kind = ident_kind(bm_d); end
        M_NUM: begin
          if ((nflags_d & NfDig) != 3'b000) begin
            eos_close = 1'b1;
            eos_kind  = mbt_pkg::TOK_NUMBER;
          end else begin
            err_d = mbt_pkg::ERR_BAD_NUMBER;
          end
        end
        M_RESAT: err_d = mbt_pkg::ERR_BAD_REF;
        M_STR, M_ESC: err_d = mbt_pkg::ERR_UNTERM_STR;
        default: ;
      endcase
      // a token whose last text beat came from this item closes on that beat
      if (eos_close) begin
        if (b_v && b_r.text_valid && !b_r.done) begin
          b_r.kind = eos_kind;
          b_r.done = 1'b1;
        end else begin
          c_v = 1'b1;
          c_r = mk(eos_kind, 8'h00, 1'b0, 1'b1, err_d);
        end
      end
      d_v = 1'b1;
      d_r = mk(mbt_pkg::TOK_EOF, 8'h00, 1'b0, 1'b1, err_d);
      mode_d     = M_IDLE;
      cur_line_d = PosOne;
      cur_col_d  = PosOne;
      tok_line_d = PosOne;
      tok_col_d  = PosOne;
      nflags_d   = 3'b000;
      bm_d       = BmNone;
      err_d      = mbt_pkg::ERR_NONE;
    end
  end

  // pack the surviving results in order
  always_comb begin
    n      = '0;
    meta_o = '0;
    line_o = '0;
    col_o  = '0;
    if (a_v) begin
      meta_o[n] = a_r; line_o[n] = tok_line_q; col_o[n] = tok_col_q;
      n = n + 2'd1;
    end
    if (b_v) begin
      meta_o[n] = b_r; line_o[n] = bc_line; col_o[n] = bc_col;
      n = n + 2'd1;
    end
    if (c_v) begin
      meta_o[n] = c_r; line_o[n] = bc_line; col_o[n] = bc_col;
      n = n + 2'd1;
    end
    if (d_v) begin
      meta_o[n] = d_r; line_o[n] = e_line; col_o[n] = e_col;
      n = n + 2'd1;
    end
  end

  assign cnt_o  = n;
  assign push_o = acc && n != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_IDLE;
      cur_line_q <= PosOne;
      cur_col_q  <= PosOne;
      tok_line_q <= PosOne;
      tok_col_q  <= PosOne;
      nflags_q   <= 3'b000;
      bm_q       <= BmNone;
      err_q      <= mbt_pkg::ERR_NONE;
    end else if (acc) begin
      mode_q     <= mode_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      nflags_q   <= nflags_d;
      bm_q       <= bm_d;
      err_q      <= err_d;
    end
  end

  // end of source puts the lexer back to its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.end_of_source |=> mode_q == M_IDLE && err_q == mbt_pkg::ERR_NONE &&
                                   cur_line_q == PosOne && cur_col_q == PosOne)
    else $error("lexer state not cleared after end of source");

  // a sticky error only lives in error mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != mbt_pkg::ERR_NONE |-> mode_q == M_ERR)
    else $error("sticky error outside error mode");

  // error mode is silent until end of source
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_ERR && acc && !in_i.end_of_source |-> !push_o)
    else $error("result produced in error mode");

endmodule

### design/mbt_queue.sv
// mbt_queue: small register queue of result bundles between front and back
// no package dependency; width and depth come from the top level
module mbt_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned Depth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         nempty_o,
  output logic [W-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [W-1:0]    mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;

  assign full_o   = count_q == CntFull;
  assign nempty_o = count_q != '0;
  assign rdata_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
      if (pop_i) rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
      if (push_i && !pop_i) count_q <= count_q + CntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CntW'(1);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntFull)
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> nempty_o)
    else $error("pop from empty queue");

endmodule

### design/mbt_back.sv
// mbt_back: walks the head bundle one result a cycle into the output register unless out_o stalls
// depends on mbt_pkg and mbt_out_if
module mbt_back #(
  parameter int unsigned PW = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic nempty_i,
  input  mbt_pkg::rcnt_t cnt_i,
  input  mbt_pkg::rslt_t [mbt_pkg::MaxResults-1:0] meta_i,
  input  logic [mbt_pkg::MaxResults-1:0][PW-1:0] line_i,
  input  logic [mbt_pkg::MaxResults-1:0][PW-1:0] col_i,
  output logic pop_o,
  mbt_out_if.source out_o
);

  mbt_pkg::rcnt_t idx_q;
  logic           ovalid_q;
  mbt_pkg::rslt_t meta_q;
  logic [PW-1:0]  line_q, col_q;
  logic           last_q;
  logic           load, last;

  assign load  = nempty_i && (!ovalid_q || out_o.ready);
  assign last  = idx_q == mbt_pkg::rcnt_t'(cnt_i - 2'd1);
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else if (load) begin
      ovalid_q <= 1'b1;
      idx_q    <= last ? '0 : idx_q + 2'd1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      meta_q <= meta_i[idx_q];
      line_q <= line_i[idx_q];
      col_q  <= col_i[idx_q];
      last_q <= last;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.token_kind   = meta_q.kind;
  assign out_o.text_byte    = meta_q.text;
  assign out_o.text_valid   = meta_q.text_valid;
  assign out_o.token_done   = meta_q.done;
  assign out_o.start_line   = line_q;
  assign out_o.start_column = col_q;
  assign out_o.error_code   = meta_q.err;
  assign out_o.last_of_item = last_q;

endmodule

### design/markup_byte_tokenizer.sv
// markup_byte_tokenizer: top level, front lexer, bundle queue and result serializer
// depends on mbt_pkg, mbt_if, mbt_front, mbt_queue and mbt_back
//
//   port   dir  beat                                    rate
//   in_i   in   one source byte and end flag            up to one a cycle
//   out_o  out  one token text byte or closing result   one a cycle when ready
//
// each input beat gives zero to three result beats
// the results of a beat pass through the bundle queue and then the output register
// out_o sends one result a cycle while ready, so items with several results set the pace
// a four-bundle queue lets the lexer keep taking bytes while the output is stalled
// reset is asynchronous and clears the lexer state, queue pointers and count and output valid
module markup_byte_tokenizer #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mbt_in_if.sink    in_i,
  mbt_out_if.source out_o
);

  localparam int unsigned PW     = POSITION_WIDTH;
  localparam int unsigned NR     = mbt_pkg::MaxResults;
  localparam int unsigned MetaW  = NR * $bits(mbt_pkg::rslt_t);
  localparam int unsigned CntW   = $bits(mbt_pkg::rcnt_t);
  localparam int unsigned PosW   = NR * PW;
  localparam int unsigned BundleW = MetaW + CntW + 2 * PosW;

  logic                         push, pop, full, nempty;
  mbt_pkg::rcnt_t               f_cnt, b_cnt;
  mbt_pkg::rslt_t [NR-1:0]      f_meta, b_meta;
  logic [NR-1:0][PW-1:0]        f_line, f_col, b_line, b_col;
  logic [BundleW-1:0]           wdata, rdata;

  mbt_front #(.PW(PW)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cnt_o  (f_cnt),
    .meta_o (f_meta),
    .line_o (f_line),
    .col_o  (f_col)
  );

  assign wdata = {f_meta, f_cnt, f_line, f_col};

  mbt_queue #(.W(BundleW), .Depth(mbt_pkg::QueueDepth)) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (wdata),
    .pop_i    (pop),
    .full_o   (full),
    .nempty_o (nempty),
    .rdata_o  (rdata)
  );

  assign {b_meta, b_cnt, b_line, b_col} = rdata;

  mbt_back #(.PW(PW)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .nempty_i (nempty),
    .cnt_i    (b_cnt),
    .meta_i   (b_meta),
    .line_i   (b_line),
    .col_i    (b_col),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

### verif/markup_byte_tokenizer_test.sv
// markup_byte_tokenizer_test: self-checking bench for the markup byte tokenizer
// depends on mbt_pkg, mbt_in_if / mbt_out_if and markup_byte_tokenizer
// a scoreboard class predicts every result beat; plain tasks drive the source side
module markup_byte_tokenizer_test;

  localparam int unsigned PosW        = 16;
  localparam int unsigned PosTop      = (1 << PosW) - 1;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned RandomBytes = 80;
  localparam int unsigned TailCycles  = 16;
  localparam int unsigned KwTrue      = 4;
  localparam int unsigned KwFalse     = 9;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChPipe   = 8'h7C;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPoint  = 8'h2E;
  localparam logic [7:0] ChUnder  = 8'h5F;

  localparam string IdentHead = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string IdentTail = "abcfrstuelzQXY_0123456789.";
  localparam string Digits    = "0123456789";

  typedef logic [PosW-1:0] pos_t;

  typedef enum int {
    LX_IDLE, LX_SLASH, LX_LINE_CMT, LX_BLOCK_CMT, LX_BLOCK_STAR, LX_IDENT,
    LX_AT, LX_NUMBER, LX_STRING, LX_ESCAPE, LX_HALTED
  } lex_state_e;

  typedef struct {
    mbt_pkg::tok_kind_e kind;
    logic [7:0]         text;
    logic               text_valid;
    logic               done;
    pos_t               line;
    pos_t               column;
    mbt_pkg::err_code_e err;
    logic               last;
  } tok_beat_t;

  class token_tracker;
    lex_state_e         mode;
    int unsigned        cur_line, cur_col, tok_line, tok_col, kw_state;
    bit                 num_digits, num_point;
    mbt_pkg::err_code_e sticky;
    tok_beat_t          item_beats[$];
    tok_beat_t          awaited_tokens[$];
    int unsigned        errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      mode       = LX_IDLE;
      cur_line   = 1;
      cur_col    = 1;
      tok_line   = 1;
      tok_col    = 1;
      kw_state   = 0;
      num_digits = 1'b0;
      num_point  = 1'b0;
      sticky     = mbt_pkg::ERR_NONE;
    endfunction

    function int unsigned pos_step(int unsigned v);
      return (v >= PosTop) ? PosTop : v + 1;
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_head(logic [7:0] c);
      return is_alpha(c) || c == ChUnder;
    endfunction

    // t-r-u-e climbs 1..4, f-a-l-s-e climbs 5..9, anything else drops the match
    function int unsigned kw_next(int unsigned m, logic [7:0] c);
      if (m == 1 && c == "r") return 2;
      if (m == 2 && c == "u") return 3;
      if (m == 3 && c == "e") return KwTrue;
      if (m == 5 && c == "a") return 6;
      if (m == 6 && c == "l") return 7;
      if (m == 7 && c == "s") return 8;
      if (m == 8 && c == "e") return KwFalse;
      return 0;
    endfunction

    function mbt_pkg::tok_kind_e word_kind();
      return (kw_state == KwTrue || kw_state == KwFalse) ? mbt_pkg::TOK_BOOL
                                                          : mbt_pkg::TOK_IDENT;
    endfunction

    function void emit(mbt_pkg::tok_kind_e k, logic [7:0] t, logic tv, logic dn,
                       int unsigned ln, int unsigned col);
      tok_beat_t b;
      if (item_beats.size() >= mbt_pkg::MaxResults) return;
      b.kind       = k;
      b.text       = t;
      b.text_valid = tv;
      b.done       = dn;
      b.line       = pos_t'(ln);
      b.column     = pos_t'(col);
      b.err        = sticky;
      b.last       = 1'b0;
      item_beats   = {item_beats, b};
    endfunction

    function void put_text(mbt_pkg::tok_kind_e k, logic [7:0] c);
      emit(k, c, 1'b1, 1'b0, tok_line, tok_col);
    endfunction

    function void close(mbt_pkg::tok_kind_e k);
      emit(k, 8'h00, 1'b0, 1'b1, tok_line, tok_col);
    endfunction

    function void halt(mbt_pkg::err_code_e code);
      sticky = code;
      mode   = LX_HALTED;
      emit(mbt_pkg::TOK_EOF, 8'h00, 1'b0, 1'b0, tok_line, tok_col);
    endfunction

    function void begin_token(logic [7:0] c);
      tok_line = cur_line;
      tok_col  = cur_col;
      case (c)
        ChSpace, ChTab, ChCr, ChLf: ;
        ChSlash:  mode = LX_SLASH;
        ChComma:  close(mbt_pkg::TOK_COMMA);
        ChPipe:   close(mbt_pkg::TOK_PIPE);
        ChLbrace: close(mbt_pkg::TOK_LBRACE);
        ChRbrace: close(mbt_pkg::TOK_RBRACE);
        ChColon:  close(mbt_pkg::TOK_COLON);
        ChAt: begin
          put_text(mbt_pkg::TOK_IDENT, c);
          mode = LX_AT;
        end
        ChQuote:  mode = LX_STRING;
        default: begin
          if (is_digit(c) || c == ChMinus || c == ChPoint) begin
            num_digits = is_digit(c);
            num_point  = (c == ChPoint);
            put_text(mbt_pkg::TOK_NUMBER, c);
            mode = LX_NUMBER;
          end else if (is_head(c)) begin
            kw_state = (c == "t") ? 1 : ((c == "f") ? 5 : 0);
            put_text(mbt_pkg::TOK_IDENT, c);
            mode = LX_IDENT;
          end else begin
            halt(mbt_pkg::ERR_UNEXPECTED);
          end
        end
      endcase
    endfunction

    function void consume(logic [7:0] c);
      logic [7:0] r;
      case (mode)
        LX_IDLE: begin_token(c);
        LX_SLASH: begin
          if (c == ChSlash) mode = LX_LINE_CMT;
          else if (c == ChStar) mode = LX_BLOCK_CMT;
          else halt(mbt_pkg::ERR_UNEXPECTED);
        end
        LX_LINE_CMT: if (c == ChLf) mode = LX_IDLE;
        LX_BLOCK_CMT: if (c == ChStar) mode = LX_BLOCK_STAR;
        LX_BLOCK_STAR: begin
          if (c == ChSlash) mode = LX_IDLE;
          else if (c != ChStar) mode = LX_BLOCK_CMT;
        end
        LX_IDENT: begin
          if (is_head(c) || is_digit(c) || c == ChPoint) begin
            kw_state = kw_next(kw_state, c);
            put_text(mbt_pkg::TOK_IDENT, c);
          end else begin
            close(word_kind());
            mode = LX_IDLE;
            begin_token(c);
          end
        end
        LX_AT: begin
          if (is_head(c)) begin
            kw_state = 0;
            put_text(mbt_pkg::TOK_IDENT, c);
            mode = LX_IDENT;
          end else begin
            halt(mbt_pkg::ERR_BAD_REF);
          end
        end
        LX_NUMBER: begin
          if (is_digit(c)) begin
            num_digits = 1'b1;
            put_text(mbt_pkg::TOK_NUMBER, c);
          end else if (c == ChPoint && !num_point) begin
            num_point = 1'b1;
            put_text(mbt_pkg::TOK_NUMBER, c);
          end else if (!num_digits) begin
            halt(mbt_pkg::ERR_BAD_NUMBER);
          end else begin
            close(mbt_pkg::TOK_NUMBER);
            mode = LX_IDLE;
            begin_token(c);
          end
        end
        LX_STRING: begin
          if (c == ChBslash) mode = LX_ESCAPE;
          else if (c == ChQuote) begin
            close(mbt_pkg::TOK_STRING);
            mode = LX_IDLE;
          end else put_text(mbt_pkg::TOK_STRING, c);
        end
        LX_ESCAPE: begin
          r = c;
          if (c == "n") r = ChLf;
          else if (c == "r") r = ChCr;
          else if (c == "t") r = ChTab;
          put_text(mbt_pkg::TOK_STRING, r);
          mode = LX_STRING;
        end
        default: ;
      endcase
    endfunction

    // a token ended by end of source folds into its last text beat of the same item
    function void close_at_end(mbt_pkg::tok_kind_e k);
      int tail;
      tail = item_beats.size() - 1;
      if (tail >= 0 && item_beats[tail].text_valid && !item_beats[tail].done) begin
        item_beats[tail].kind = k;
        item_beats[tail].done = 1'b1;
      end else begin
        close(k);
      end
    endfunction

    function void take_source_beat(logic [7:0] c, logic bv, logic eos);
      item_beats.delete();
      if (bv && mode != LX_HALTED) begin
        consume(c);
        if (c == ChLf) begin
          cur_line = pos_step(cur_line);
          cur_col  = 1;
        end else begin
          cur_col = pos_step(cur_col);
        end
      end
      if (eos) begin
        case (mode)
          LX_SLASH: sticky = mbt_pkg::ERR_UNEXPECTED;
          LX_IDENT: close_at_end(word_kind());
          LX_NUMBER: begin
            if (num_digits) close_at_end(mbt_pkg::TOK_NUMBER);
            else sticky = mbt_pkg::ERR_BAD_NUMBER;
          end
          LX_AT: sticky = mbt_pkg::ERR_BAD_REF;
          LX_STRING, LX_ESCAPE: sticky = mbt_pkg::ERR_UNTERM_STR;
          default: ;
        endcase
        emit(mbt_pkg::TOK_EOF, 8'h00, 1'b0, 1'b1, cur_line, cur_col);
        restart();
      end
      if (item_beats.size() > 0) item_beats[item_beats.size() - 1].last = 1'b1;
      foreach (item_beats[i]) awaited_tokens = {awaited_tokens, item_beats[i]};
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_token_beat(logic [3:0] kind, logic [7:0] text, logic tv, logic dn,
                                   pos_t ln, pos_t col, logic [2:0] err, logic lst);
      tok_beat_t want;
      if (awaited_tokens.size() == 0) begin
        $error("result beat with nothing awaited: kind %0d text %02h", kind, text);
        errors++;
        return;
      end
      want = awaited_tokens.pop_front();
      match_field("token_kind", 32'(want.kind), 32'(kind));
      match_field("text_byte", 32'(want.text), 32'(text));
      match_field("text_valid", 32'(want.text_valid), 32'(tv));
      match_field("token_done", 32'(want.done), 32'(dn));
      match_field("start_line", 32'(want.line), 32'(ln));
      match_field("start_column", 32'(want.column), 32'(col));
      match_field("error_code", 32'(want.err), 32'(err));
      match_field("last_of_item", 32'(want.last), 32'(lst));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned src_gap_pct = 30;
  int unsigned sink_gap_pct = 30;
  int unsigned sink_hold = 0;
  int unsigned quiet_cycles = 0;
  token_tracker tracker = new();

  mbt_in_if in_if();
  mbt_out_if #(.PW(PosW)) out_if();

  markup_byte_tokenizer #(
    .POSITION_WIDTH(PosW)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: ready changes on the falling edge, a long hold counts down here
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_if.ready = 1'b0;
        sink_hold--;
      end else begin
        out_if.ready = ($urandom_range(99) >= sink_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      tracker.check_token_beat(out_if.token_kind, out_if.text_byte, out_if.text_valid,
                               out_if.token_done, out_if.start_line, out_if.start_column,
                               out_if.error_code, out_if.last_of_item);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("markup_byte_tokenizer verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] c);
    q = {q, c};
  endfunction

  function automatic void add_text(ref logic [7:0] q[$], input string s);
    foreach (s[i]) add_byte(q, s[i]);
  endfunction

  function automatic void add_fragment(ref logic [7:0] q[$]);
    logic [7:0] c;
    case ($urandom_range(19))
      0, 1: begin
        repeat ($urandom_range(1, 3)) add_byte(q, pick_char(" \t\n\015"));
      end
      2, 3, 4: add_byte(q, pick_char(",|{}:"));
      5, 6, 7: begin
        add_byte(q, pick_char(IdentHead));
        repeat ($urandom_range(0, 5)) add_byte(q, pick_char(IdentTail));
      end
      8: begin
        case ($urandom_range(5))
          0: add_text(q, "true");
          1: add_text(q, "false");
          2: add_text(q, "tru");
          3: add_text(q, "falsey");
          4: add_text(q, "t");
          default: add_text(q, "f_1");
        endcase
      end
      9: begin
        add_byte(q, ChAt);
        add_byte(q, pick_char(IdentHead));
        repeat ($urandom_range(0, 4)) add_byte(q, pick_char(IdentTail));
      end
      10, 11: begin
        if ($urandom_range(2) == 0) add_byte(q, ChMinus);
        c = 8'($urandom_range(0, 3));
        repeat (c) add_byte(q, pick_char(Digits));
        if (c == 0 || $urandom_range(1) == 1) begin
          add_byte(q, ChPoint);
          repeat ((c == 0) ? $urandom_range(1, 2) : $urandom_range(0, 3))
            add_byte(q, pick_char(Digits));
        end
      end
      12, 13: begin
        add_byte(q, ChQuote);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(2) == 0) begin
            add_byte(q, ChBslash);
            add_byte(q, pick_char("nrt\"\\q0"));
          end else begin
            c = 8'($urandom_range(255));
            if (c == ChQuote || c == ChBslash) c = "z";
            add_byte(q, c);
          end
        end
        add_byte(q, ChQuote);
      end
      14: begin
        add_text(q, "//");
        repeat ($urandom_range(0, 4)) add_byte(q, 8'($urandom_range(255)));
        add_byte(q, ChLf);
      end
      15: begin
        add_text(q, "/*");
        repeat ($urandom_range(0, 5)) add_byte(q, pick_char("**/ a\n"));
        add_text(q, "*/");
      end
      16: add_byte(q, 8'($urandom_range(255)));
      default: begin
        // malformed openings that stop the source with an error
        case ($urandom_range(4))
          0: add_text(q, "@1");
          1: add_text(q, "@ ");
          2: add_text(q, "-x");
          3: add_text(q, "-.,");
          default: add_text(q, "/x");
        endcase
      end
    endcase
  endfunction

  task automatic send_item(input logic [7:0] c, input logic bv, input logic eos);
    while ($urandom_range(99) < src_gap_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid         = 1'b1;
    in_if.source_byte   = c;
    in_if.byte_valid    = bv;
    in_if.end_of_source = eos;
    do @(posedge clk); while (!in_if.ready);
    tracker.take_source_beat(c, bv, eos);
    @(negedge clk);
  endtask

  // split_end puts end of source on a beat of its own with no byte
  task automatic send_source(input logic [7:0] q[$], input bit split_end, input bit with_gaps);
    foreach (q[i]) begin
      if (with_gaps && $urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(q[i], 1'b1, !split_end && i == q.size() - 1);
    end
    if (split_end) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic wait_results_done();
    in_if.valid = 1'b0;
    while (tracker.awaited_tokens.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [7:0] text_q[$];
    int unsigned bytes_sent;
    int unsigned src_no;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.source_byte   = 8'h00;
    in_if.byte_valid    = 1'b0;
    in_if.end_of_source = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // every token kind, an escape, a beat with no byte, an ident closed by a bare end
    send_item(8'h5A, 1'b0, 1'b0);
    text_q = {};
    add_text(text_q, "{x:-1.5,\"\\q\"|true}fals");
    send_source(text_q, 1'b1, 1'b0);
    // sources cut short: lone slash, open string, lone at, sign with no digits
    send_item(ChSlash, 1'b1, 1'b1);
    send_item(ChQuote, 1'b1, 1'b1);
    send_item(ChAt, 1'b1, 1'b1);
    send_item(ChMinus, 1'b1, 1'b1);
    // bad byte mid-source, the rest is ignored until the end
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    wait_results_done();

    bytes_sent = 0;
    src_no     = 0;
    while (bytes_sent < RandomBytes) begin
      // the first two sources run with no idling on either side
      src_gap_pct  = (src_no < 2) ? 0 : 30;
      sink_gap_pct = src_gap_pct;
      text_q = {};
      repeat ($urandom_range(2, 6)) begin
        add_fragment(text_q);
        if ($urandom_range(1) == 1) add_byte(text_q, ChSpace);
      end
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(7))
          0: add_text(text_q, "\"ab");
          1: add_text(text_q, "\"x\\");
          2: add_text(text_q, "/*x*");
          3: add_text(text_q, "//z");
          4: add_text(text_q, "@");
          5: add_text(text_q, "-");
          6: add_text(text_q, "-.");
          default: add_text(text_q, "/");
        endcase
      end
      send_source(text_q, $urandom_range(2) == 0, 1'b1);
      bytes_sent += text_q.size();
      src_no++;
    end
    src_gap_pct  = 30;
    sink_gap_pct = 30;
    wait_results_done();

    // result side blocked while bytes keep coming, so the queue fills and input stalls
    sink_hold   = 300;
    src_gap_pct = 0;
    text_q = {};
    add_byte(text_q, ChQuote);
    repeat (24) add_byte(text_q, pick_char(IdentTail));
    add_text(text_q, "\" name: 12.5, ");
    send_source(text_q, 1'b0, 1'b0);
    src_gap_pct = 30;
    wait_results_done();

    repeat (TailCycles) @(negedge clk);
    if (tracker.errors == 0 && tracker.awaited_tokens.size() == 0) begin
      $display("markup_byte_tokenizer verification clean");
    end else begin
      $display("markup_byte_tokenizer verification failed");
    end
    $finish;
  end

endmodule

### files.f
design/mbt_pkg.sv
design/mbt_if.sv
design/mbt_front.sv
design/mbt_queue.sv
design/mbt_back.sv
design/markup_byte_tokenizer.sv
verif/markup_byte_tokenizer_test.sv
